// ----- rtl/psrb_pkg.sv -----
package psrb_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int BLOCK_DEPTH = 64;

	localparam int ADDR_W   = 32;
	localparam int COUNT_W  = 24;
	localparam int THRESH_W = 16;
	localparam int ELAPSED_W = 8;
	localparam int LIMIT_W  = 24;
	localparam int USED_W   = $clog2(TABLE_DEPTH + 1);
	localparam int BUSED_W  = $clog2(BLOCK_DEPTH + 1);
	localparam int BIDX_W   = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [1:0] KIND_COUNTED     = 2'd0;
	localparam logic [1:0] KIND_NOT_TRACKED = 2'd1;
	localparam logic [1:0] KIND_BLOCKED     = 2'd2;
	localparam logic [1:0] KIND_TICK_DONE   = 2'd3;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic REG_RATE_THRESHOLD = 1'b0;

	typedef struct packed {
		logic                 operation;
		logic [ADDR_W-1:0]    src_addr;
		logic [ELAPSED_W-1:0] elapsed_seconds;
	} in_req_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [ADDR_W-1:0]  address;
		logic [COUNT_W-1:0] count;
		logic               list_full;
		logic               last;
	} out_req_t;

	typedef struct packed {
		logic              inc;
		logic              shift;
		logic              clear;
		logic [ADDR_W-1:0] key;
	} cell_cmd_t;

	typedef struct packed {
		logic               valid;
		logic               hit;
		logic [ADDR_W-1:0]  addr;
		logic [COUNT_W-1:0] count;
	} cell_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PKT,
		ST_TCHK,
		ST_BRD,
		ST_BCMP,
		ST_NEW,
		ST_FIN
	} state_t;

endpackage

// ----- rtl/psrb_cell.sv -----
module psrb_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  psrb_pkg::cell_cmd_t cmd,
	input  logic                ins,
	input  psrb_pkg::cell_out_t nbr,
	output psrb_pkg::cell_out_t cur
);
	import psrb_pkg::*;

	logic               valid_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [COUNT_W-1:0] count_q;
	logic               hit;

	assign hit = valid_q && (addr_q == cmd.key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.shift) begin
			valid_q <= nbr.valid;
		end else if (ins) begin
			valid_q <= 1'b1;
		end
	end

	// take neighbour's entry on shift, load new source on insert, count on hit
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			addr_q  <= nbr.addr;
			count_q <= nbr.count;
		end else if (ins) begin
			addr_q  <= cmd.key;
			count_q <= COUNT_W'(1);
		end else if (cmd.inc && hit && count_q != COUNT_MAX) begin
			count_q <= count_q + COUNT_W'(1);
		end
	end

	assign cur.valid = valid_q;
	assign cur.hit   = hit;
	assign cur.addr  = addr_q;
	assign cur.count = count_q;

endmodule

// ----- rtl/per_source_rate_blocker.sv -----
// Per-source packet rate blocker. Packet requests (operation 0) look up their
// source address in a row of 64 cells by parallel compare:
// accept, then compare and update. A hit bumps the count (saturating), a miss
// inserts a new cell, and a full table reports "not tracked". Tick requests
// (operation 1) with nonzero elapsed seconds walk the row by shifting every
// cell towards cell 0 once per entry; an entry whose count exceeds
// rate_threshold * elapsed_seconds is checked against the blocked-list memory
// one word at a time, each word read and then compared (single read port,
// registered data). After a tick the table is empty. A zero-second tick
// changes nothing. Results pass through an output register, so a waiting
// result does not hold off the next request.
// rate_threshold sits at byte address 0 of the APB port and resets to 1.
module per_source_rate_blocker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  psrb_pkg::in_req_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output psrb_pkg::out_req_t                 out_data,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [psrb_pkg::PADDR_W-1:0]       paddr,
	input  logic [psrb_pkg::PDATA_W-1:0]       pwdata,
	output logic [psrb_pkg::PDATA_W-1:0]       prdata,
	output logic                               pready
);
	import psrb_pkg::*;

	// configuration
	logic [THRESH_W-1:0] threshold_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RATE_THRESHOLD) ? PDATA_W'(threshold_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESH_W'(1);
		end else if (psel && penable && pwrite && paddr[2] == REG_RATE_THRESHOLD) begin
			threshold_q <= pwdata[THRESH_W-1:0];
		end
	end

	// control state
	state_t             state_q, state_d;
	logic [ADDR_W-1:0]  key_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [USED_W-1:0]  used_q;
	logic [USED_W-1:0]  rem_q;
	logic [BUSED_W-1:0] bused_q;
	logic [BUSED_W-1:0] bidx_q;
	logic [ADDR_W-1:0]  rdata_q;
	logic               out_valid_q;
	out_req_t           out_q;
	logic               pend_valid_q;
	out_req_t           pend_q;

	logic      accept;
	logic      can_emit;
	cell_cmd_t cmd;
	logic      ins_en;
	logic      emit;
	out_req_t  emit_data;
	logic      pend_load;
	logic      pend_clr;
	logic      blk_wr;
	logic      bidx_inc;
	logic      bidx_clr;
	logic      rem_dec;
	logic      used_inc;
	logic      used_clr;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign can_emit  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// cell row: cell 0 is the head seen by the tick walk
	cell_out_t          cell_o [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] ins;
	cell_out_t          tail;

	assign tail = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		assign ins[i] = ins_en && (used_q == USED_W'(i));
		psrb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.ins    (ins[i]),
			.nbr    ((i == TABLE_DEPTH - 1) ? tail : cell_o[(i + 1) % TABLE_DEPTH]),
			.cur    (cell_o[i])
		);
	end

	// gather the hit (at most one cell matches)
	logic               any_hit;
	logic [COUNT_W-1:0] hit_count;
	logic [COUNT_W-1:0] hit_next;

	always_comb begin
		any_hit   = 1'b0;
		hit_count = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			any_hit   = any_hit | cell_o[i].hit;
			hit_count = hit_count | (cell_o[i].hit ? cell_o[i].count : '0);
		end
		hit_next = (hit_count == COUNT_MAX) ? COUNT_MAX : hit_count + COUNT_W'(1);
	end

	// blocked list memory
	logic [ADDR_W-1:0] blk_mem [BLOCK_DEPTH];

	always_ff @(posedge clk) begin
		if (blk_wr) begin
			blk_mem[bused_q[BIDX_W-1:0]] <= cell_o[0].addr;
		end
		rdata_q <= blk_mem[bidx_q[BIDX_W-1:0]];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_data.operation == OP_PACKET) begin
						state_d = ST_PKT;
					end else if (in_data.elapsed_seconds == '0) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_TCHK;
					end
				end
			end
			ST_PKT: begin
				if (can_emit) state_d = ST_IDLE;
			end
			ST_TCHK: begin
				if (rem_q == '0) begin
					state_d = ST_FIN;
				end else if (cell_o[0].count > limit_q) begin
					state_d = ST_BRD;
				end
			end
			ST_BRD: begin
				state_d = (bidx_q == bused_q) ? ST_NEW : ST_BCMP;
			end
			ST_BCMP: begin
				state_d = (rdata_q == cell_o[0].addr) ? ST_TCHK : ST_BRD;
			end
			ST_NEW: begin
				if (!pend_valid_q || can_emit) state_d = ST_TCHK;
			end
			ST_FIN: begin
				if (can_emit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd       = '0;
		cmd.key   = key_q;
		ins_en    = 1'b0;
		emit      = 1'b0;
		emit_data = '0;
		pend_load = 1'b0;
		pend_clr  = 1'b0;
		blk_wr    = 1'b0;
		bidx_inc  = 1'b0;
		bidx_clr  = 1'b0;
		rem_dec   = 1'b0;
		used_inc  = 1'b0;
		used_clr  = 1'b0;
		case (state_q)
			ST_IDLE: ;
			ST_PKT: begin
				if (can_emit) begin
					emit              = 1'b1;
					emit_data.address = key_q;
					emit_data.last    = 1'b1;
					if (any_hit) begin
						cmd.inc         = 1'b1;
						emit_data.kind  = KIND_COUNTED;
						emit_data.count = hit_next;
					end else if (used_q < USED_W'(TABLE_DEPTH)) begin
						ins_en          = 1'b1;
						used_inc        = 1'b1;
						emit_data.kind  = KIND_COUNTED;
						emit_data.count = COUNT_W'(1);
					end else begin
						emit_data.kind  = KIND_NOT_TRACKED;
					end
				end
			end
			ST_TCHK: begin
				if (rem_q == '0) begin
					cmd.clear = 1'b1;
					used_clr  = 1'b1;
				end else if (cell_o[0].count > limit_q) begin
					bidx_clr = 1'b1;
				end else begin
					cmd.shift = 1'b1;
					rem_dec   = 1'b1;
				end
			end
			ST_BRD: ;
			ST_BCMP: begin
				if (rdata_q == cell_o[0].addr) begin
					cmd.shift = 1'b1;
					rem_dec   = 1'b1;
				end else begin
					bidx_inc = 1'b1;
				end
			end
			ST_NEW: begin
				if (!pend_valid_q || can_emit) begin
					emit      = pend_valid_q;
					emit_data = pend_q;
					pend_load = 1'b1;
					blk_wr    = (bused_q < BUSED_W'(BLOCK_DEPTH));
					cmd.shift = 1'b1;
					rem_dec   = 1'b1;
				end
			end
			ST_FIN: begin
				if (can_emit) begin
					emit     = 1'b1;
					pend_clr = 1'b1;
					if (pend_valid_q) begin
						emit_data      = pend_q;
						emit_data.last = 1'b1;
					end else begin
						emit_data.kind = KIND_TICK_DONE;
						emit_data.last = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			used_q       <= '0;
			rem_q        <= '0;
			bused_q      <= '0;
			bidx_q       <= '0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (used_clr) begin
				used_q <= '0;
			end else if (used_inc) begin
				used_q <= used_q + USED_W'(1);
			end
			if (accept) begin
				rem_q <= used_q;
			end else if (rem_dec) begin
				rem_q <= rem_q - USED_W'(1);
			end
			if (blk_wr) bused_q <= bused_q + BUSED_W'(1);
			if (bidx_clr) begin
				bidx_q <= '0;
			end else if (bidx_inc) begin
				bidx_q <= bidx_q + BUSED_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pend_clr) begin
				pend_valid_q <= 1'b0;
			end else if (pend_load) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q   <= in_data.src_addr;
			limit_q <= LIMIT_W'(threshold_q) * LIMIT_W'(in_data.elapsed_seconds);
		end
		if (emit) out_q <= emit_data;
		if (pend_load) begin
			pend_q.kind      <= KIND_BLOCKED;
			pend_q.address   <= cell_o[0].addr;
			pend_q.count     <= cell_o[0].count;
			pend_q.list_full <= (bused_q >= BUSED_W'(BLOCK_DEPTH));
			pend_q.last      <= 1'b0;
		end
	end

endmodule
